FILE: design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants and types of the set-associative LRU tag tracker:
// configuration register indexes, fixed port widths and lookup status.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAY_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef struct packed {
        logic hit;
        logic evicted;
    } lookup_status_t;

endpackage

FILE: design/set_assoc_cache_lru_tracker.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tracker
// Set-associative cache tag store with exact LRU replacement and saturating
// hit, miss and eviction counters.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one byte address per item; m_* channel returns one
//   result per item: hit, evicted, way used and the three running counters.
//   cfg_we/cfg_index/cfg_data write set_bits, way_count and block_bits; a
//   write to a known index empties the store and clears the counters.
//   Write configuration only while no item is in flight.
// Path: accept -> lookup stage register -> output registers.
// Throughput: one item per cycle unless the output stalls. Each item reads
//   its set row from the RAM in the accept cycle, writes the updated row back
//   on leaving lookup; the next item to the same set gets it by forwarding.
// Reset: all sets read as empty straight away (one flag flip-flop per set,
//   no clearing pass), ranks equal the way index, counters are zero,
//   set_bits = 0, way_count = 1, block_bits = 0.
// Stall: while m_ready is low the result holds, the item in the lookup
//   stage waits and s_ready drops once that stage is occupied.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tracker #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ADDR_BITS-1:0]            s_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic                            m_evicted,
    output logic [sacl_pkg::WAY_OUT_W-1:0]  m_way_used,
    output logic [sacl_pkg::CNT_W-1:0]      m_hit_count,
    output logic [sacl_pkg::CNT_W-1:0]      m_miss_count,
    output logic [sacl_pkg::CNT_W-1:0]      m_eviction_count
);

    localparam int CFG_W    = sacl_pkg::CFG_DATA_W;
    localparam int CNT_W    = sacl_pkg::CNT_W;
    localparam int OUT_W    = sacl_pkg::WAY_OUT_W;
    localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << SET_IW;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int ROW_W    = MAX_WAYS * (1 + ADDR_BITS + WAY_W);
    localparam int SHAMT_W  = CFG_W + 1;

    // configuration
    logic [CFG_W-1:0] set_bits_reg;
    logic [CFG_W-1:0] way_count_reg;
    logic [CFG_W-1:0] block_bits_reg;
    logic             cfg_hit;

    // control
    logic                busy_reg;
    logic                busy_next;
    logic                accept;
    logic                finish;
    logic [NUM_SETS-1:0] row_init_reg;

    // lookup stage
    logic [SET_IW-1:0]    set_reg;
    logic [SET_IW-1:0]    set_next;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [ADDR_BITS-1:0] tag_next;
    logic                 rowv_reg;
    logic                 fwd_reg;
    logic                 fwd_next;
    logic [ROW_W-1:0]     fwd_row_reg;

    logic [CFG_W-1:0]     set_eff;
    logic [SET_IW-1:0]    set_mask;
    logic [ADDR_BITS-1:0] blk_addr;
    logic [SHAMT_W-1:0]   tag_shamt;
    logic [NCNT_W-1:0]    way_num;

    logic [ROW_W-1:0]                   ram_rdata;
    logic [ROW_W-1:0]                   cur_row;
    logic [ROW_W-1:0]                   wr_row;
    logic [MAX_WAYS-1:0]                cur_valid;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] cur_tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]     cur_rank;
    logic [MAX_WAYS-1:0][WAY_W-1:0]     init_rank;
    logic [MAX_WAYS-1:0]                upd_valid;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] upd_tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]     upd_rank;
    sacl_pkg::lookup_status_t           status;
    logic [WAY_W-1:0]                   way_sel;

    // output and counters
    logic             m_valid_reg;
    logic             m_hit_reg;
    logic             m_evicted_reg;
    logic [OUT_W-1:0] m_way_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] evict_cnt_reg;

    assign cfg_hit = cfg_we && ((cfg_index == sacl_pkg::CFG_SET_BITS) ||
                                (cfg_index == sacl_pkg::CFG_WAY_COUNT) ||
                                (cfg_index == sacl_pkg::CFG_BLOCK_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= '0;
            way_count_reg  <= CFG_W'(1);
            block_bits_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                sacl_pkg::CFG_SET_BITS:   set_bits_reg   <= cfg_data;
                sacl_pkg::CFG_WAY_COUNT:  way_count_reg  <= cfg_data;
                sacl_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp configuration to the built geometry
    always_comb begin
        set_eff = (int'(set_bits_reg) > MAX_SET_BITS) ? CFG_W'(MAX_SET_BITS) : set_bits_reg;
        if (way_count_reg == '0) begin
            way_num = NCNT_W'(1);
        end else if (int'(way_count_reg) > MAX_WAYS) begin
            way_num = NCNT_W'(MAX_WAYS);
        end else begin
            way_num = NCNT_W'(way_count_reg);
        end
        for (int i = 0; i < SET_IW; i++) begin
            set_mask[i] = (i < int'(set_eff));
        end
    end

    assign blk_addr  = s_address >> block_bits_reg;
    assign set_next  = blk_addr[SET_IW-1:0] & set_mask;
    assign tag_shamt = SHAMT_W'(block_bits_reg) + SHAMT_W'(set_eff);
    assign tag_next  = s_address >> tag_shamt;

    // handshake
    assign finish    = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !busy_reg || finish;
    assign accept    = s_valid && s_ready;
    assign busy_next = accept ? 1'b1 : (finish ? 1'b0 : busy_reg);
    assign fwd_next  = finish && (set_next == set_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            row_init_reg <= '0;
        end else if (finish) begin
            row_init_reg[set_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg     <= set_next;
            tag_reg     <= tag_next;
            rowv_reg    <= row_init_reg[set_next];
            fwd_reg     <= fwd_next;
            fwd_row_reg <= wr_row;
        end
    end

    sacl_row_ram #(
        .ADDR_W (SET_IW),
        .ROW_W  (ROW_W)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (finish),
        .wr_addr (set_reg),
        .wr_data (wr_row),
        .rd_en   (accept),
        .rd_addr (set_next),
        .rd_data (ram_rdata)
    );

    // row as the lookup sees it: forwarded, never written, or from the RAM
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            init_rank[w] = WAY_W'(w);
        end
        if (fwd_reg) begin
            cur_row = fwd_row_reg;
        end else if (!rowv_reg) begin
            cur_row = {{MAX_WAYS{1'b0}}, {(MAX_WAYS * ADDR_BITS){1'b0}}, init_rank};
        end else begin
            cur_row = ram_rdata;
        end
    end

    assign {cur_valid, cur_tag, cur_rank} = cur_row;

    sacl_lru_update #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_lru_update (
        .way_num   (way_num),
        .tag       (tag_reg),
        .old_valid (cur_valid),
        .old_tag   (cur_tag),
        .old_rank  (cur_rank),
        .status    (status),
        .way_sel   (way_sel),
        .new_valid (upd_valid),
        .new_tag   (upd_tag),
        .new_rank  (upd_rank)
    );

    assign wr_row = {upd_valid, upd_tag, upd_rank};

    // counters saturate at all ones
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end else if (finish) begin
            if (status.hit && !(&hit_cnt_reg)) begin
                hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
            end
            if (!status.hit && !(&miss_cnt_reg)) begin
                miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
            end
            if (status.evicted && !(&evict_cnt_reg)) begin
                evict_cnt_reg <= evict_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_hit_reg     <= status.hit;
            m_evicted_reg <= status.evicted;
            m_way_reg     <= OUT_W'(way_sel);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_evicted        = m_evicted_reg;
    assign m_way_used       = m_way_reg;
    assign m_hit_count      = hit_cnt_reg;
    assign m_miss_count     = miss_cnt_reg;
    assign m_eviction_count = evict_cnt_reg;

endmodule

FILE: design/sacl_row_ram.sv
// ----------------------------------------------------------------------------
// sacl_row_ram
// Single-port-write, single-port-read synchronous RAM holding one row
// (valid bits, tags and recency ranks of all ways) per set.
// ----------------------------------------------------------------------------
module sacl_row_ram #(
    parameter int ADDR_W = 8,
    parameter int ROW_W  = 288
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [ROW_W-1:0] mem [0:DEPTH-1];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-first: a same-cycle write is handled by forwarding upstream
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/sacl_lru_update.sv
// ----------------------------------------------------------------------------
// sacl_lru_update
// Tag compare over all ways of one set, victim choice by exact LRU rank and
// the updated row to write back.
// ----------------------------------------------------------------------------
module sacl_lru_update #(
    parameter  int MAX_WAYS  = 8,
    parameter  int ADDR_BITS = 32,
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int NCNT_W    = $clog2(MAX_WAYS + 1)
) (
    input  logic [NCNT_W-1:0]                  way_num,
    input  logic [ADDR_BITS-1:0]               tag,
    input  logic [MAX_WAYS-1:0]                old_valid,
    input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] old_tag,
    input  logic [MAX_WAYS-1:0][WAY_W-1:0]     old_rank,
    output sacl_pkg::lookup_status_t           status,
    output logic [WAY_W-1:0]                   way_sel,
    output logic [MAX_WAYS-1:0]                new_valid,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tag,
    output logic [MAX_WAYS-1:0][WAY_W-1:0]     new_rank
);

    always_comb begin
        logic [MAX_WAYS-1:0] in_use;
        logic                hit_found;
        logic                vic_found;
        logic [WAY_W-1:0]    hit_way;
        logic [WAY_W-1:0]    vic_way;
        logic [WAY_W-1:0]    sel;
        logic [WAY_W-1:0]    sel_rank;

        hit_found = 1'b0;
        vic_found = 1'b0;
        hit_way   = '0;
        vic_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (NCNT_W'(w) < way_num);
            if (!hit_found && in_use[w] && old_valid[w] && (old_tag[w] == tag)) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            // least recent way in use; never-used ways hold the lowest ranks in order
            if (!vic_found && in_use[w] && (old_rank[w] == '0)) begin
                vic_found = 1'b1;
                vic_way   = WAY_W'(w);
            end
        end

        sel      = hit_found ? hit_way : vic_way;
        sel_rank = old_rank[sel];

        status.hit     = hit_found;
        status.evicted = !hit_found && old_valid[sel];
        way_sel        = sel;

        new_valid = old_valid;
        new_tag   = old_tag;
        new_rank  = old_rank;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j]) begin
                if (WAY_W'(j) == sel) begin
                    new_rank[j] = WAY_W'(way_num - NCNT_W'(1));
                end else if (old_rank[j] > sel_rank) begin
                    new_rank[j] = old_rank[j] - WAY_W'(1);
                end
            end
        end
        if (!hit_found) begin
            new_valid[sel] = 1'b1;
            new_tag[sel]   = tag;
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: set-associative LRU tag tracker testbench
// Sends byte addresses through the s_ channel with random gaps while the m_
// channel stalls at random. Each accepted address is run through a local tag
// store with exact LRU ranks and saturating counters, and every result is
// checked field by field. Covers reset defaults, LRU replacement order,
// clamped register values, writes to the unused register index, and random
// traffic over working sets under a range of register settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_SET_BITS   = 8;
    localparam int MAX_WAYS       = 8;
    localparam int ADDR_BITS      = 32;
    localparam int NUM_SETS       = 1 << MAX_SET_BITS;
    localparam int WATCHDOG_LIMIT = 400;
    localparam logic [sacl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        sacl_pkg::lookup_status_t       status;
        logic [sacl_pkg::WAY_OUT_W-1:0] way_used;
        logic [sacl_pkg::CNT_W-1:0]     hit_count;
        logic [sacl_pkg::CNT_W-1:0]     miss_count;
        logic [sacl_pkg::CNT_W-1:0]     eviction_count;
    } lookup_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic [ADDR_BITS-1:0]            s_address = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic                            m_hit;
    logic                            m_evicted;
    logic [sacl_pkg::WAY_OUT_W-1:0]  m_way_used;
    logic [sacl_pkg::CNT_W-1:0]      m_hit_count;
    logic [sacl_pkg::CNT_W-1:0]      m_miss_count;
    logic [sacl_pkg::CNT_W-1:0]      m_eviction_count;

    // local copy of the tag store and registers
    logic                            line_ok    [NUM_SETS][MAX_WAYS];
    logic [ADDR_BITS-1:0]            line_tag_q [NUM_SETS][MAX_WAYS];
    logic [2:0]                      line_rank  [NUM_SETS][MAX_WAYS];
    logic [sacl_pkg::CNT_W-1:0]      hits_seen;
    logic [sacl_pkg::CNT_W-1:0]      misses_seen;
    logic [sacl_pkg::CNT_W-1:0]      evictions_seen;
    logic [sacl_pkg::CFG_DATA_W-1:0] cur_set_bits;
    logic [sacl_pkg::CFG_DATA_W-1:0] cur_way_count;
    logic [sacl_pkg::CFG_DATA_W-1:0] cur_block_bits;

    lookup_result_t pending_lookups[$];
    int             mismatch_count = 0;
    int             quiet_cycles   = 0;
    int             gap_pct        = 20;
    int             stall_pct      = 20;
    int             stall_left     = 0;

    set_assoc_cache_lru_tracker #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_address        (s_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_evicted        (m_evicted),
        .m_way_used       (m_way_used),
        .m_hit_count      (m_hit_count),
        .m_miss_count     (m_miss_count),
        .m_eviction_count (m_eviction_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(6, 20);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(
        input logic [sacl_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_store();
        for (int st = 0; st < NUM_SETS; st++) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                line_ok[st][w]    = 1'b0;
                line_tag_q[st][w] = '0;
                line_rank[st][w]  = 3'(w);
            end
        end
        hits_seen      = '0;
        misses_seen    = '0;
        evictions_seen = '0;
    endfunction

    function automatic lookup_result_t cache_access(input logic [ADDR_BITS-1:0] a);
        lookup_result_t r;
        int             s;
        int             n;
        int             set_idx;
        int             way;
        int             w;
        int             old_rank;
        logic [ADDR_BITS-1:0] tag;
        bit             found;
        bit             evict;
        s = (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
        n = (cur_way_count == 0) ? 1 :
            (cur_way_count > MAX_WAYS) ? MAX_WAYS : int'(cur_way_count);
        set_idx = int'((a >> cur_block_bits) & ((32'd1 << s) - 1));
        tag = a >> (int'(cur_block_bits) + s);
        found = 1'b0;
        evict = 1'b0;
        way = 0;
        for (w = 0; w < n; w++) begin
            if (!found && line_ok[set_idx][w] && line_tag_q[set_idx][w] == tag) begin
                found = 1'b1;
                way = w;
            end
        end
        if (found) begin
            hits_seen = sat_inc(hits_seen);
        end else begin
            misses_seen = sat_inc(misses_seen);
            // least recent way; never-used ways hold the lowest ranks
            for (w = n - 1; w >= 0; w--) begin
                if (line_rank[set_idx][w] == 0)
                    way = w;
            end
            if (line_ok[set_idx][way]) begin
                evict = 1'b1;
                evictions_seen = sat_inc(evictions_seen);
            end
            line_ok[set_idx][way]    = 1'b1;
            line_tag_q[set_idx][way] = tag;
        end
        // promote the way used to most recent
        old_rank = line_rank[set_idx][way];
        for (w = 0; w < n; w++) begin
            if (line_rank[set_idx][w] > old_rank)
                line_rank[set_idx][w] = line_rank[set_idx][w] - 1'b1;
        end
        line_rank[set_idx][way] = 3'(n - 1);
        r.status.hit      = found;
        r.status.evicted  = evict;
        r.way_used        = sacl_pkg::WAY_OUT_W'(way);
        r.hit_count       = hits_seen;
        r.miss_count      = misses_seen;
        r.eviction_count  = evictions_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // predict on acceptance, then check any result in the same edge
    always @(posedge aclk) begin
        lookup_result_t want;
        bit             moved;
        if (!aresetn) begin
            cur_set_bits   = '0;
            cur_way_count  = sacl_pkg::CFG_DATA_W'(1);
            cur_block_bits = '0;
            clear_store();
            pending_lookups.delete();
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    sacl_pkg::CFG_SET_BITS: begin
                        cur_set_bits = cfg_data;
                        clear_store();
                    end
                    sacl_pkg::CFG_WAY_COUNT: begin
                        cur_way_count = cfg_data;
                        clear_store();
                    end
                    sacl_pkg::CFG_BLOCK_BITS: begin
                        cur_block_bits = cfg_data;
                        clear_store();
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pending_lookups.push_back(cache_access(s_address));
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (pending_lookups.size() == 0) begin
                    $display("%0t: result with nothing expected, hit %0b way %0d",
                             $time, m_hit, m_way_used);
                    mismatch_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("hit", 32'(want.status.hit), 32'(m_hit));
                    check_field("evicted", 32'(want.status.evicted), 32'(m_evicted));
                    check_field("way_used", 32'(want.way_used), 32'(m_way_used));
                    check_field("hit_count", want.hit_count, m_hit_count);
                    check_field("miss_count", want.miss_count, m_miss_count);
                    check_field("eviction_count", want.eviction_count,
                                m_eviction_count);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // result back-pressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = idle_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // valid is left high on return; the next call drops it only for a gap
    task automatic send_access(input logic [ADDR_BITS-1:0] a);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat (idle_len()) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_address <= a;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lookups.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic cfg_write(input logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sacl_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic cfg_done();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [sacl_pkg::CFG_DATA_W-1:0] sb,
                             input logic [sacl_pkg::CFG_DATA_W-1:0] wc,
                             input logic [sacl_pkg::CFG_DATA_W-1:0] bb);
        drain_results();
        cfg_write(sacl_pkg::CFG_SET_BITS, sb);
        cfg_write(sacl_pkg::CFG_WAY_COUNT, wc);
        cfg_write(sacl_pkg::CFG_BLOCK_BITS, bb);
        cfg_done();
    endtask

    task automatic test_reset_defaults();
        // one way, one set: a zero tag must still miss on an empty store
        send_access(32'h0000_0000);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'hFFFF_FFFF);
    endtask

    task automatic test_lru_replacement();
        // two sets, four ways, four-byte blocks; set index is address bit 2
        configure(4'd1, 4'd4, 4'd2);
        send_access(32'h08);
        send_access(32'h10);
        send_access(32'h18);
        send_access(32'h20);
        send_access(32'h0B);
        send_access(32'h28);
        send_access(32'h10);
        send_access(32'h0C);
    endtask

    task automatic test_clamped_config();
        configure(4'hF, 4'hF, 4'hF);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        send_access(32'hFF80_7FFF);
        // zero ways acts as a single way
        configure(4'h0, 4'h0, 4'h0);
        send_access(32'h1);
        send_access(32'h2);
        send_access(32'h1);
    endtask

    task automatic test_ignored_index();
        configure(4'd2, 4'd2, 4'd4);
        send_access(32'h40);
        send_access(32'h40);
        drain_results();
        cfg_write(CFG_UNUSED, 4'hF);
        cfg_done();
        // store and counters must survive the write
        send_access(32'h4F);
    endtask

    task automatic test_random_traffic(input logic [sacl_pkg::CFG_DATA_W-1:0] sb,
                                       input logic [sacl_pkg::CFG_DATA_W-1:0] wc,
                                       input logic [sacl_pkg::CFG_DATA_W-1:0] bb,
                                       input int n_items, input int gaps,
                                       input int stalls);
        logic [ADDR_BITS-1:0] tag_pool[$];
        logic [ADDR_BITS-1:0] a;
        logic [ADDR_BITS-1:0] tg;
        int                   set_pool[2];
        int                   s;
        int                   n;
        int                   st;
        int                   pick;
        configure(sb, wc, bb);
        gap_pct   = gaps;
        stall_pct = stalls;
        s = (sb > MAX_SET_BITS) ? MAX_SET_BITS : int'(sb);
        n = (wc == 0) ? 1 : (wc > MAX_WAYS) ? MAX_WAYS : int'(wc);
        // a few more tags than ways keeps both hits and evictions frequent
        for (int i = 0; i < n + 2; i++)
            tag_pool.push_back($urandom);
        set_pool[0] = $urandom_range(0, (1 << s) - 1);
        set_pool[1] = $urandom_range(0, (1 << s) - 1);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                a = $urandom;
            end else begin
                tg = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
                st = (pick < 25) ? $urandom_range(0, (1 << s) - 1)
                                 : set_pool[$urandom_range(0, 1)];
                a = (tg << (int'(bb) + s)) | (ADDR_BITS'(st) << bb)
                  | ($urandom & ((32'd1 << bb) - 1));
            end
            send_access(a);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_lru_replacement();
        test_clamped_config();
        test_ignored_index();

        test_random_traffic(4'd0,  4'd1,  4'd0,  128, 20, 20);
        test_random_traffic(4'd8,  4'd8,  4'd12, 128, 0,  0);
        test_random_traffic(4'd15, 4'd15, 4'd15, 128, 40, 40);
        test_random_traffic(4'd2,  4'd2,  4'd4,  128, 10, 50);
        test_random_traffic(4'd3,  4'd4,  4'd5,  128, 50, 10);
        test_random_traffic(4'd1,  4'd8,  4'd0,  128, 0,  30);
        test_random_traffic(4'd4,  4'd3,  4'd6,  128, 30, 0);
        test_random_traffic(4'd0,  4'd8,  4'd3,  128, 20, 20);
        test_random_traffic(4'd6,  4'd5,  4'd2,  128, 60, 60);
        test_random_traffic(4'd8,  4'd1,  4'd12, 128, 15, 15);
        test_random_traffic(4'd5,  4'd0,  4'd7,  128, 25, 35);

        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: set_assoc_cache_lru_tracker.f
design/sacl_pkg.sv
design/sacl_row_ram.sv
design/sacl_lru_update.sv
design/set_assoc_cache_lru_tracker.sv
tb/tb_top.sv
